// ===== rtl/bfha_pkg.sv =====
// Shared types and constants for the best-fit heap allocator.
package bfha_pkg;

  localparam int unsigned Descriptors = 16;
  localparam int unsigned IdxW = $clog2(Descriptors);
  localparam int unsigned CntW = $clog2(Descriptors + 1);
  localparam int unsigned RankW = IdxW;
  localparam logic [31:0] AlignBytes = 32'd8;
  localparam logic [31:0] AlignMask = ~(AlignBytes - 32'd1);

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_USED  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_FREE    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_SMALL    = 3'd4
  } status_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;   // capture input transaction
    logic clear;  // reset scan results
    logic scan;   // examine entry at scan index
    logic commit; // apply update and form result
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

// ===== rtl/bfha_datapath.sv =====
// Descriptor table, scan logic and update logic of the allocator.
module bfha_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfha_pkg::dp_cmd_t    cmd_i,
  output bfha_pkg::dp_sts_t    sts_o,
  input  logic [1:0]           mode_i,
  input  logic [31:0]          size_i,
  input  logic [31:0]          addr_i,
  input  logic [7:0]           perm_i,
  output logic [31:0]          res_addr_o,
  output logic [31:0]          res_count_o,
  output logic [2:0]           res_status_o
);

  bfha_pkg::kind_e                   kind_q [bfha_pkg::Descriptors];
  logic [31:0]                       start_q [bfha_pkg::Descriptors];
  logic [31:0]                       len_q [bfha_pkg::Descriptors];
  logic [7:0]                        perm_q [bfha_pkg::Descriptors];
  logic [bfha_pkg::RankW-1:0]        rank_q [bfha_pkg::Descriptors];

  logic [1:0]  mode_q;
  logic [31:0] size_q, addr_q;
  logic [7:0]  perm_in_q;
  logic [bfha_pkg::IdxW-1:0] idx_q;

  // Scan results.
  logic exact_v_q, best_v_q, hit_v_q, empty_v_q;
  logic [bfha_pkg::IdxW-1:0] exact_q, best_q, hit_q, empty_q;
  logic [bfha_pkg::RankW-1:0] exact_rk_q, best_rk_q, hit_rk_q;
  logic [31:0] best_len_q;

  logic [31:0] res_addr_q, res_count_q;
  logic [2:0]  res_status_q;

  assign sts_o.scan_last = (idx_q == bfha_pkg::IdxW'(bfha_pkg::Descriptors - 1));
  assign res_addr_o   = res_addr_q;
  assign res_count_o  = res_count_q;
  assign res_status_o = res_status_q;

  bfha_pkg::kind_e             sk;
  logic [31:0]                 sl, ss;
  logic [bfha_pkg::RankW-1:0]  sr;
  logic                        pm;
  assign sk = kind_q[idx_q];
  assign sl = len_q[idx_q];
  assign ss = start_q[idx_q];
  assign sr = rank_q[idx_q];
  assign pm = (perm_q[idx_q] & perm_in_q) != 8'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_i;
      size_q    <= size_i;
      addr_q    <= addr_i;
      perm_in_q <= perm_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      exact_v_q <= 1'b0;
      best_v_q  <= 1'b0;
      hit_v_q   <= 1'b0;
      empty_v_q <= 1'b0;
    end else if (cmd_i.clear) begin
      idx_q     <= '0;
      exact_v_q <= 1'b0;
      best_v_q  <= 1'b0;
      hit_v_q   <= 1'b0;
      empty_v_q <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + 1'b1;
      if (sk == bfha_pkg::KIND_EMPTY && !empty_v_q) begin
        empty_v_q <= 1'b1;
      end
      if (sk == bfha_pkg::KIND_FREE && pm) begin
        if (sl == size_q) begin
          if (!exact_v_q || sr < exact_rk_q) begin
            exact_v_q <= 1'b1;
          end
        end else if (sl > size_q) begin
          if (!best_v_q || sl < best_len_q || (sl == best_len_q && sr < best_rk_q)) begin
            best_v_q <= 1'b1;
          end
        end
      end
      if (sk == bfha_pkg::KIND_USED && ss == addr_q && (!hit_v_q || sr < hit_rk_q)) begin
        hit_v_q <= 1'b1;
      end
    end
  end

  // Payload of scan results, updated under the same conditions as the flags.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (sk == bfha_pkg::KIND_EMPTY && !empty_v_q) begin
        empty_q <= idx_q;
      end
      if (sk == bfha_pkg::KIND_FREE && pm) begin
        if (sl == size_q) begin
          if (!exact_v_q || sr < exact_rk_q) begin
            exact_q    <= idx_q;
            exact_rk_q <= sr;
          end
        end else if (sl > size_q) begin
          if (!best_v_q || sl < best_len_q || (sl == best_len_q && sr < best_rk_q)) begin
            best_q     <= idx_q;
            best_rk_q  <= sr;
            best_len_q <= sl;
          end
        end
      end
      if (sk == bfha_pkg::KIND_USED && ss == addr_q && (!hit_v_q || sr < hit_rk_q)) begin
        hit_q    <= idx_q;
        hit_rk_q <= sr;
      end
    end
  end

  // Commit decision.
  logic        do_push, do_drop;
  logic [bfha_pkg::IdxW-1:0] push_e, drop_e;
  bfha_pkg::kind_e push_k, drop_k;
  logic [bfha_pkg::RankW-1:0] drop_r;
  logic        wr_new, split;
  logic [31:0] al_cnt, al_addr;
  logic [31:0] r_addr, r_cnt;
  bfha_pkg::status_e r_st;

  assign al_cnt  = (size_q - bfha_pkg::AlignBytes) & bfha_pkg::AlignMask;
  assign al_addr = (addr_q + bfha_pkg::AlignBytes) & bfha_pkg::AlignMask;

  always_comb begin
    do_push = 1'b0;
    do_drop = 1'b0;
    push_e  = empty_q;
    drop_e  = exact_q;
    push_k  = bfha_pkg::KIND_FREE;
    drop_k  = bfha_pkg::KIND_FREE;
    drop_r  = exact_rk_q;
    wr_new  = 1'b0;
    split   = 1'b0;
    r_addr  = '0;
    r_cnt   = '0;
    r_st    = bfha_pkg::ST_OK;
    case (bfha_pkg::mode_e'(mode_q))
      bfha_pkg::MODE_ADD: begin
        if (size_q < bfha_pkg::AlignBytes) begin
          r_st = bfha_pkg::ST_SMALL;
        end else if (!empty_v_q) begin
          r_st = bfha_pkg::ST_FULL;
        end else begin
          r_cnt   = al_cnt;
          r_addr  = al_addr;
          do_push = 1'b1;
          wr_new  = 1'b1;
        end
      end
      bfha_pkg::MODE_REQUEST: begin
        if (exact_v_q) begin
          r_addr  = start_q[exact_q];
          r_cnt   = size_q;
          do_drop = 1'b1;
          do_push = 1'b1;
          push_e  = exact_q;
          push_k  = bfha_pkg::KIND_USED;
        end else if (best_v_q) begin
          if (!empty_v_q) begin
            r_st = bfha_pkg::ST_FULL;
          end else begin
            r_addr  = start_q[best_q];
            r_cnt   = size_q;
            split   = 1'b1;
            do_push = 1'b1;
            push_k  = bfha_pkg::KIND_USED;
            wr_new  = 1'b1;
          end
        end else begin
          r_st = bfha_pkg::ST_NOFIT;
        end
      end
      bfha_pkg::MODE_FREE: begin
        if (hit_v_q) begin
          r_cnt   = len_q[hit_q];
          do_drop = 1'b1;
          drop_e  = hit_q;
          drop_k  = bfha_pkg::KIND_USED;
          drop_r  = hit_rk_q;
          do_push = 1'b1;
          push_e  = hit_q;
          push_k  = bfha_pkg::KIND_FREE;
        end else begin
          r_st = bfha_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Descriptor update: push sets the kind; for ranks, drop closes the gap in the old list and push shifts the new list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bfha_pkg::Descriptors; i++) begin
        kind_q[i] <= bfha_pkg::KIND_EMPTY;
      end
    end else if (cmd_i.commit && do_push) begin
      kind_q[push_e] <= push_k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_addr_q   <= r_addr;
      res_count_q  <= r_cnt;
      res_status_q <= r_st;
      for (int i = 0; i < bfha_pkg::Descriptors; i++) begin
        if (do_push && bfha_pkg::IdxW'(i) == push_e) begin
          rank_q[i] <= '0;
        end else begin
          if (do_drop && kind_q[i] == drop_k && rank_q[i] > drop_r) begin
            // entry ranked behind the dropped one moves up; it cannot also be in the push list
            rank_q[i] <= rank_q[i] - 1'b1;
          end else if (do_push && kind_q[i] == push_k) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end
      if (wr_new) begin
        start_q[push_e] <= r_addr;
        len_q[push_e]   <= wr_new && !split ? al_cnt : size_q;
        perm_q[push_e]  <= perm_in_q;
      end
      if (do_drop && push_k == bfha_pkg::KIND_USED) begin
        perm_q[drop_e] <= perm_in_q;
      end
      if (split) begin
        start_q[best_q] <= start_q[best_q] + size_q;
        len_q[best_q]   <= len_q[best_q] - size_q;
      end
    end
  end

endmodule

// ===== rtl/bfha_ctrl.sv =====
// Controller state machine for the allocator: accept, scan, commit, deliver.
module bfha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bfha_pkg::dp_cmd_t cmd_o,
  input  bfha_pkg::dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_OUT    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/best_fit_heap_allocator_core.sv =====
// Best-fit heap allocator over a table of block descriptors.
// Each transaction is accepted, scanned over every descriptor, committed, then
// delivered; no new one is accepted until the result is taken. The scan reads
// one descriptor per cycle.
// Reset (rst_ni low, asynchronous) empties every descriptor and idles the controller.
module best_fit_heap_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // block_size[31:0], block_address[63:32], perm_flags[71:64]
  input  logic [1:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata  // result_address[31:0], byte_count[63:32], status[66:64]
);

  bfha_pkg::dp_cmd_t cmd;
  bfha_pkg::dp_sts_t sts;
  logic [2:0] st;

  bfha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bfha_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mode_i      (s_axis_tuser),
    .size_i      (s_axis_tdata[31:0]),
    .addr_i      (s_axis_tdata[63:32]),
    .perm_i      (s_axis_tdata[71:64]),
    .res_addr_o  (m_axis_tdata[31:0]),
    .res_count_o (m_axis_tdata[63:32]),
    .res_status_o(st)
  );

  assign m_axis_tdata[71:64] = {5'd0, st};

endmodule

// ===== rtl/bfha_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
module bfha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // Never accept input while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  // No result directly after an accept.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");

  // Status stays in its legal range.
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:64] <= 8'd4) else $error("bad status");

  // Held result stays stable.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("result changed");

endmodule

bind best_fit_heap_allocator_core bfha_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);
